// ----- design/qro_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qro_pkg
// Shared types and constants for the range observer.
// ----------------------------------------------------------------------------
package qro_pkg;

    localparam logic CMD_OBSERVE = 1'b0;
    localparam logic CMD_DERIVE  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_ZERO  = 2'd2;

    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_WEIGHT = 1'b1;

    localparam int WEIGHT_BITS = 17;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 17'd655;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE   = 17'd65536;

    typedef struct packed {
        logic        cmd;
        logic [15:0] slot;
        logic        in_range;
        logic [31:0] obs_min;
        logic [31:0] obs_max;
        logic        asym;
    } qro_item_t;

endpackage
`default_nettype wire

// ----- design/qro_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qro_fifo
// Two-entry item queue between the front end and the back end.
// ----------------------------------------------------------------------------
module qro_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire qro_pkg::qro_item_t   push_item,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      not_empty,
    output qro_pkg::qro_item_t        head
);
    import qro_pkg::*;

    qro_item_t  mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ----- design/qro_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qro_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qro_divider #(
    parameter int NUM_BITS = 48,
    parameter int DEN_BITS = 50
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [NUM_BITS-1:0] numerator,
    input  wire logic [DEN_BITS-1:0] denominator,
    output logic                     done,
    output logic [NUM_BITS-1:0]      quotient
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] quot_reg;
    logic [DEN_BITS:0]   rem_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [DEN_BITS:0]   trial;

    assign trial    = {rem_reg[DEN_BITS-1:0], quot_reg[NUM_BITS-1]};
    assign done     = done_reg;
    assign quotient = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quot_reg <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                quot_reg <= numerator;
                rem_reg  <= '0;
                den_reg  <= denominator;
                cnt_reg  <= CNT_BITS'(NUM_BITS);
            end
            else if (busy_reg)
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_reg  <= trial - {1'b0, den_reg};
                    quot_reg <= {quot_reg[NUM_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= trial;
                    quot_reg <= {quot_reg[NUM_BITS-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- design/qro_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qro_front
// Accept input items, classify slot range, push into the queue.
// ----------------------------------------------------------------------------
module qro_front #(
    parameter int SLOTS = 256
) (
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               cmd,
    input  wire logic [7:0]         slot,
    input  wire logic [31:0]        observed_min,
    input  wire logic [31:0]        observed_max,
    input  wire logic               asymmetric_flag,
    input  wire logic               q_full,
    output logic                    push,
    output qro_pkg::qro_item_t      push_item
);
    import qro_pkg::*;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        push_item          = '0;
        push_item.cmd      = cmd;
        push_item.slot     = {8'd0, slot};
        push_item.in_range = (32'(slot) < 32'(SLOTS));
        push_item.obs_min  = observed_min;
        push_item.obs_max  = observed_max;
        push_item.asym     = asymmetric_flag;
    end
endmodule
`default_nettype wire

// ----- design/qro_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qro_back
// Execute queued items: range table update, scale and zero point derive.
// ----------------------------------------------------------------------------
module qro_back #(
    parameter int SLOTS      = 256,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_mode,
    input  wire logic [16:0]           cfg_weight,
    input  wire logic                  q_not_empty,
    input  wire qro_pkg::qro_item_t    q_head,
    output logic                       q_pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [31:0]                scale,
    output logic [31:0]                zero_pt,
    output logic                       is_asymmetric,
    output logic [1:0]                 status
);
    import qro_pkg::*;

    localparam int VB   = VALUE_BITS;
    localparam int IDXB = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NUMB = 42 + VB;
    localparam int DENB = VB + 2;
    localparam int PRB  = VB + 19;

    typedef enum logic [3:0] {
        ST_IDLE, ST_READ, ST_MUL, ST_WRITE, ST_DPREP, ST_SDIV,
        ST_SWAIT, ST_ZDIV, ST_ZWAIT, ST_OUT
    } state_t;

    logic signed [VB-1:0] low_mem  [SLOTS];
    logic signed [VB-1:0] high_mem [SLOTS];
    logic                 asym_mem [SLOTS];
    logic [SLOTS-1:0]     valid_reg;

    state_t               state_reg;
    qro_item_t            item_reg;
    logic [IDXB-1:0]      idx;
    logic signed [VB-1:0] rd_low_reg, rd_high_reg;
    logic                 rd_asym_reg;
    logic signed [VB-1:0] mn_reg, mx_reg;
    logic signed [PRB-1:0] sum_low_reg, sum_high_reg;
    logic signed [DENB-1:0] den_reg;
    logic signed [DENB-1:0] lo_reg;
    logic                 zneg_reg;
    logic                 sat_flag_reg;
    logic [31:0]          scale_reg, zp_reg;
    logic                 asym_out_reg;
    logic [1:0]           status_reg;
    logic                 out_valid_reg;
    logic                 div_start;
    logic [NUMB-1:0]      div_num;
    logic [DENB-1:0]      div_den;
    logic                 div_done;
    logic [NUMB-1:0]      div_q;
    logic                 slot_ok;
    logic [16:0]          cw;

    logic signed [VB-1:0] new_low, new_high, in_min, in_max;
    logic signed [DENB-1:0] mlo, mabs, zdiff;

    function automatic logic signed [VB-1:0] clampv(input logic [31:0] x);
        logic signed [47:0] v;
        logic signed [47:0] hi;
        logic signed [47:0] lo;
        begin
            v  = 48'(signed'(x));
            hi = (48'sd1 <<< (VB - 1)) - 48'sd1;
            lo = -hi - 48'sd1;
            if (v > hi)
            begin
                clampv = VB'(hi);
            end
            else if (v < lo)
            begin
                clampv = VB'(lo);
            end
            else
            begin
                clampv = VB'(v);
            end
        end
    endfunction

    assign idx     = IDXB'(item_reg.slot);
    assign slot_ok = item_reg.in_range && valid_reg[idx];
    assign cw      = (cfg_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg_weight;
    assign in_min  = clampv(item_reg.obs_min);
    assign in_max  = clampv(item_reg.obs_max);
    assign q_pop   = (state_reg == ST_IDLE) && q_not_empty;

    assign mlo   = (rd_low_reg < 0) ? -DENB'(rd_low_reg) : DENB'(rd_low_reg);
    assign mabs  = (DENB'(rd_high_reg) > mlo) ? DENB'(rd_high_reg) : mlo;
    assign zdiff = DENB'(rd_high_reg) - DENB'(rd_low_reg);

    always_comb
    begin
        new_low  = rd_low_reg;
        new_high = rd_high_reg;
        if (!cfg_mode)
        begin
            if (mn_reg < rd_low_reg)
            begin
                new_low = mn_reg;
            end
            if (mx_reg > rd_high_reg)
            begin
                new_high = mx_reg;
            end
        end
        else
        begin
            new_low  = VB'((sum_low_reg + PRB'(32768)) >>> 16);
            new_high = VB'((sum_high_reg + PRB'(32768)) >>> 16);
        end
    end

    assign div_start = (state_reg == ST_SDIV) || (state_reg == ST_ZDIV);

    always_comb
    begin
        div_num = '0;
        div_den = DENB'(den_reg);
        if (state_reg == ST_ZDIV)
        begin
            div_num = NUMB'(lo_reg) * NUMB'(255);
        end
        else if (rd_asym_reg)
        begin
            div_num = NUMB'(255) << 32;
        end
        else
        begin
            div_num = NUMB'(255) << 31;
        end
    end

    qro_divider #(
        .NUM_BITS(NUMB),
        .DEN_BITS(DENB)
    ) u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .numerator(div_num),
        .denominator(div_den),
        .done(div_done),
        .quotient(div_q)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_not_empty)
        begin
            item_reg <= q_head;
        end
        if (state_reg == ST_READ)
        begin
            rd_low_reg  <= low_mem[idx];
            rd_high_reg <= high_mem[idx];
            rd_asym_reg <= asym_mem[idx];
            mn_reg      <= in_min;
            mx_reg      <= in_max;
        end
        if (state_reg == ST_MUL)
        begin
            sum_low_reg  <= PRB'(rd_low_reg) * PRB'(signed'({1'b0, 17'd65536 - cw}))
                          + PRB'(mn_reg) * PRB'(signed'({1'b0, cw}));
            sum_high_reg <= PRB'(rd_high_reg) * PRB'(signed'({1'b0, 17'd65536 - cw}))
                          + PRB'(mx_reg) * PRB'(signed'({1'b0, cw}));
        end
        if (state_reg == ST_WRITE)
        begin
            if (!valid_reg[idx])
            begin
                low_mem[idx]  <= mn_reg;
                high_mem[idx] <= mx_reg;
                asym_mem[idx] <= item_reg.asym;
            end
            else
            begin
                low_mem[idx]  <= new_low;
                high_mem[idx] <= new_high;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            scale_reg     <= '0;
            zp_reg        <= '0;
            asym_out_reg  <= 1'b0;
            status_reg    <= STATUS_OK;
            den_reg       <= '0;
            lo_reg        <= '0;
            zneg_reg      <= 1'b0;
            sat_flag_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_not_empty)
                    begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    if (item_reg.cmd == CMD_OBSERVE)
                    begin
                        state_reg <= item_reg.in_range ? ST_MUL : ST_IDLE;
                    end
                    else if (!slot_ok)
                    begin
                        scale_reg    <= '0;
                        zp_reg       <= '0;
                        asym_out_reg <= 1'b0;
                        status_reg   <= STATUS_EMPTY;
                        state_reg    <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_DPREP;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    valid_reg[idx] <= 1'b1;
                    state_reg      <= ST_IDLE;
                end
                ST_DPREP:
                begin
                    asym_out_reg <= rd_asym_reg;
                    status_reg   <= STATUS_OK;
                    if (rd_asym_reg)
                    begin
                        if (rd_high_reg == rd_low_reg)
                        begin
                            den_reg      <= DENB'(131072);
                            lo_reg       <= DENB'(65536);
                            zneg_reg     <= 1'b1;
                            sat_flag_reg <= 1'b0;
                        end
                        else if (zdiff[DENB-1])
                        begin
                            den_reg      <= -zdiff;
                            lo_reg       <= mlo;
                            zneg_reg     <= (rd_low_reg < 0) ^ zdiff[DENB-1];
                            sat_flag_reg <= 1'b1;
                        end
                        else
                        begin
                            den_reg      <= zdiff;
                            lo_reg       <= mlo;
                            zneg_reg     <= (rd_low_reg < 0) ^ zdiff[DENB-1];
                            sat_flag_reg <= 1'b0;
                        end
                        state_reg <= ST_SDIV;
                    end
                    else if (mabs == '0)
                    begin
                        scale_reg    <= '1;
                        zp_reg       <= 32'd128;
                        status_reg   <= STATUS_ZERO;
                        sat_flag_reg <= 1'b0;
                        state_reg    <= ST_OUT;
                    end
                    else
                    begin
                        den_reg      <= mabs;
                        zp_reg       <= 32'd128;
                        sat_flag_reg <= 1'b0;
                        state_reg    <= ST_SDIV;
                    end
                end
                ST_SDIV:
                begin
                    state_reg <= ST_SWAIT;
                end
                ST_SWAIT:
                begin
                    if (div_done)
                    begin
                        if (sat_flag_reg)
                        begin
                            scale_reg <= '0;
                        end
                        else if (div_q > NUMB'(32'hFFFF_FFFF))
                        begin
                            scale_reg <= '1;
                        end
                        else
                        begin
                            scale_reg <= div_q[31:0];
                        end
                        state_reg <= rd_asym_reg ? ST_ZDIV : ST_OUT;
                    end
                end
                ST_ZDIV:
                begin
                    state_reg <= ST_ZWAIT;
                end
                ST_ZWAIT:
                begin
                    if (div_done)
                    begin
                        if (!zneg_reg)
                        begin
                            zp_reg <= (div_q > NUMB'(32'h8000_0000)) ? 32'h8000_0000
                                    : 32'(-(div_q[31:0]));
                        end
                        else
                        begin
                            zp_reg <= (div_q > NUMB'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                    : div_q[31:0];
                        end
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        if (item_reg.in_range)
                        begin
                            valid_reg[idx] <= 1'b0;
                        end
                    end
                    else if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign scale         = scale_reg;
    assign zero_pt       = zp_reg;
    assign is_asymmetric = asym_out_reg;
    assign status        = status_reg;
endmodule
`default_nettype wire

// ----- design/quant_range_observer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quant_range_observer
// Table of observed value ranges with scale and zero point derivation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries cmd, slot, observed_min,
//   observed_max and asymmetric_flag. Observe items update the slot and
//   give no result; derive items give one result on out_valid/out_stall
//   (scale, zero_pt, is_asymmetric, status) and free the slot.
//   A two-entry queue sits between the front end and the executing back end;
//   an accepted item waits in the queue until the idle back end pops it.
//   Observe: the back end steps through pop, read, multiply and write; a
//   slot beyond the table ends after the read.
//   Derive: the shared bit-serial divider forms scale and, for an asymmetric
//   slot, then the zero point; an empty slot or a symmetric slot with a zero
//   divisor skips the divider.
//   Reset clears all slot valid bits and resets the control, queue and output
//   registers; no clearing pass.
//   A stalled result holds and the back end waits; the queue then fills and
//   in_stall rises. Write configuration only while idle.
// ----------------------------------------------------------------------------
module quant_range_observer #(
    parameter int SLOTS      = 256,
    parameter int VALUE_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [16:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        cmd,
    input  wire logic [7:0]  slot,
    input  wire logic [31:0] observed_min,
    input  wire logic [31:0] observed_max,
    input  wire logic        asymmetric_flag,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      scale,
    output logic [31:0]      zero_pt,
    output logic             is_asymmetric,
    output logic [1:0]       status
);
    import qro_pkg::*;

    logic        mode_reg;
    logic [16:0] weight_reg;
    logic        push, q_full, q_pop, q_not_empty;
    qro_item_t   push_item, q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            weight_reg <= WEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_data[0];
                REG_WEIGHT: weight_reg <= cfg_data;
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    qro_front #(.SLOTS(SLOTS)) u_front (
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .slot(slot),
        .observed_min(observed_min),
        .observed_max(observed_max),
        .asymmetric_flag(asymmetric_flag),
        .q_full(q_full),
        .push(push),
        .push_item(push_item)
    );

    qro_fifo u_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_item(push_item),
        .full(q_full),
        .pop(q_pop),
        .not_empty(q_not_empty),
        .head(q_head)
    );

    qro_back #(.SLOTS(SLOTS), .VALUE_BITS(VALUE_BITS)) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_mode(mode_reg),
        .cfg_weight(weight_reg),
        .q_not_empty(q_not_empty),
        .q_head(q_head),
        .q_pop(q_pop),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .scale(scale),
        .zero_pt(zero_pt),
        .is_asymmetric(is_asymmetric),
        .status(status)
    );
endmodule
`default_nettype wire

// ----- design/qro_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qro_checker
// Port-level checks bound to the range observer.
// ----------------------------------------------------------------------------
module qro_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] scale,
    input wire logic [31:0] zero_pt,
    input wire logic [1:0]  status,
    input wire logic        is_asymmetric
);
    import qro_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(scale))
        else $error("result dropped under stall");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("bad status");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_EMPTY |-> scale == '0 && !is_asymmetric)
        else $error("empty result not zeroed");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_ZERO |-> zero_pt == 32'd128 && !is_asymmetric)
        else $error("zero divisor result wrong");
endmodule

bind quant_range_observer qro_checker u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .scale(scale),
    .zero_pt(zero_pt),
    .status(status),
    .is_asymmetric(is_asymmetric)
);
`default_nettype wire

// ----- verif/quant_range_observer_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quant_range_observer_check
// Watches the configuration port and both item channels of the range
// observer, keeps its own copy of the range table, works out the scale and
// zero point each derive should give, and compares every result in order.
// ----------------------------------------------------------------------------
module quant_range_observer_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        cmd,
    input  logic [7:0]  slot,
    input  logic [31:0] observed_min,
    input  logic [31:0] observed_max,
    input  logic        asymmetric_flag,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] scale,
    input  logic [31:0] zero_pt,
    input  logic        is_asymmetric,
    input  logic [1:0]  status,
    output int          failures,
    output int          pending,
    output int          results_seen
);
    import qro_pkg::*;

    typedef struct {
        logic [31:0] scale;
        logic [31:0] zero_pt;
        logic        asym;
        logic [1:0]  status;
    } quant_params_t;

    quant_params_t params_due[$];
    longint        range_lo [256];
    longint        range_hi [256];
    bit            asym_mark [256];
    bit            filled [256];
    bit            avg_mode;
    logic [16:0]   weight;

    assign pending = params_due.size();

    function automatic longint moving_avg(longint old, longint obs, longint c);
        longint s;
        s = old * (65536 - c) + obs * c;
        return (s + 32768) >>> 16;
    endfunction

    function automatic logic [31:0] clip_scale(longint q);
        if (q < 0)
            return 32'd0;
        if (q > 64'sd4294967295)
            return 32'hFFFF_FFFF;
        return q[31:0];
    endfunction

    function automatic quant_params_t derive_params(int s);
        quant_params_t r;
        longint lo;
        longint hi;
        longint d;
        longint m;
        longint z;
        r.scale = 32'd0;
        r.zero_pt = 32'd0;
        r.asym = 1'b0;
        r.status = STATUS_EMPTY;
        if (!filled[s])
            return r;
        lo = range_lo[s];
        hi = range_hi[s];
        r.asym = asym_mark[s];
        r.status = STATUS_OK;
        if (asym_mark[s]) begin
            if (hi == lo) begin
                lo = -65536;
                hi = 65536;
            end
            d = hi - lo;
            r.scale = clip_scale((longint'(255) <<< 32) / d);
            z = (-255 * lo) / d;
            if (z > 64'sd2147483647)
                z = 64'sd2147483647;
            if (z < -64'sd2147483648)
                z = -64'sd2147483648;
            r.zero_pt = z[31:0];
        end
        else begin
            m = (lo < 0) ? -lo : lo;
            if (hi > m)
                m = hi;
            if (m == 0) begin
                r.scale = 32'hFFFF_FFFF;
                r.status = STATUS_ZERO;
            end
            else
                r.scale = clip_scale((longint'(255) <<< 31) / m);
            r.zero_pt = 32'd128;
        end
        filled[s] = 1'b0;
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, want);
        failures++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        quant_params_t r;
        longint mn;
        longint mx;
        longint c;
        if (!rst_n) begin
            foreach (filled[i])
                filled[i] = 1'b0;
            avg_mode = 1'b0;
            weight = WEIGHT_RESET;
            params_due.delete();
            failures = 0;
            results_seen = 0;
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == REG_MODE)
                    avg_mode = cfg_data[0];
                else
                    weight = cfg_data;
            end
            if (in_valid && !in_stall) begin
                mn = longint'($signed(observed_min));
                mx = longint'($signed(observed_max));
                if (cmd == CMD_DERIVE)
                    params_due.insert(params_due.size(), derive_params(int'(slot)));
                else if (!filled[slot]) begin
                    range_lo[slot] = mn;
                    range_hi[slot] = mx;
                    asym_mark[slot] = asymmetric_flag;
                    filled[slot] = 1'b1;
                end
                else if (!avg_mode) begin
                    if (mn < range_lo[slot])
                        range_lo[slot] = mn;
                    if (mx > range_hi[slot])
                        range_hi[slot] = mx;
                end
                else begin
                    c = (weight > WEIGHT_ONE) ? 65536 : longint'(weight);
                    range_lo[slot] = moving_avg(range_lo[slot], mn, c);
                    range_hi[slot] = moving_avg(range_hi[slot], mx, c);
                end
            end
            if (out_valid && !out_stall) begin
                results_seen++;
                if (params_due.size() == 0) begin
                    report("unexpected result", scale, 32'd0);
                end
                else begin
                    r = params_due.pop_front();
                    if (scale !== r.scale)
                        report("scale", scale, r.scale);
                    if (zero_pt !== r.zero_pt)
                        report("zero_pt", zero_pt, r.zero_pt);
                    if (is_asymmetric !== r.asym)
                        report("is_asymmetric", 32'(is_asymmetric), 32'(r.asym));
                    if (status !== r.status)
                        report("status", 32'(status), 32'(r.status));
                end
            end
        end
    end

endmodule

// ----- verif/quant_range_observer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quant_range_observer_test
// Drives directed corner items and random observe/derive sequences into the
// range observer under several averaging settings, with bursty input and
// stalled output, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module quant_range_observer_test;
    import qro_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [16:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        cmd;
    logic [7:0]  slot;
    logic [31:0] observed_min;
    logic [31:0] observed_max;
    logic        asymmetric_flag;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] scale;
    logic [31:0] zero_pt;
    logic        is_asymmetric;
    logic [1:0]  status;
    int          failures;
    int          pending;
    int          results_seen;
    int          burst_left;
    int          observes_sent;
    int          derives_sent;

    quant_range_observer DUT (.*);
    quant_range_observer_check checker_inst (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge clk)
    begin
        int stall_kind;
        int tick;
        tick++;
        if (tick % 97 == 0)
            stall_kind = $urandom_range(0, 3);
        case (stall_kind)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 9) < 3);
            2: out_stall <= ((tick % 40) < 25);
            default: out_stall <= tick[0];
        endcase
    end

    task automatic send(logic c, logic [7:0] s, logic [31:0] mn, logic [31:0] mx, logic af);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd <= c;
        slot <= s;
        observed_min <= mn;
        observed_max <= mx;
        asymmetric_flag <= af;
        if (c == CMD_DERIVE)
            derives_sent++;
        else
            observes_sent++;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [16:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_traffic(int count);
        logic [7:0]  s;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] t;
        int n;
        while (count > 0) begin
            if ($urandom_range(0, 9) == 0) begin
                send(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), $urandom,
                     $urandom, 1'($urandom_range(0, 1)));
                count--;
            end
            else begin
                s = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 7))
                                               : 8'($urandom_range(0, 255));
                n = $urandom_range(1, 4);
                repeat (n) begin
                    a = pick_value();
                    b = pick_value();
                    if ($signed(a) > $signed(b) && $urandom_range(0, 9) < 8) begin
                        t = a;
                        a = b;
                        b = t;
                    end
                    send(CMD_OBSERVE, s, a, b, 1'($urandom_range(0, 1)));
                end
                if ($urandom_range(0, 9) < 9)
                    send(CMD_DERIVE, s, $urandom, $urandom, 1'($urandom_range(0, 1)));
                count -= n + 1;
            end
        end
    endtask

    initial
    begin
        logic [16:0] weights [6];
        logic        modes [6];
        rst_n = 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_MODE;
        cfg_data <= '0;
        in_valid <= 1'b0;
        cmd <= CMD_OBSERVE;
        slot <= '0;
        observed_min <= '0;
        observed_max <= '0;
        asymmetric_flag <= 1'b0;
        burst_left = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(CMD_DERIVE, 8'd5, 32'h0, 32'h0, 1'b0);
        send(CMD_OBSERVE, 8'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send(CMD_DERIVE, 8'd0, 32'h0, 32'h0, 1'b0);
        send(CMD_OBSERVE, 8'd1, 32'h0003_0000, 32'h0003_0000, 1'b1);
        send(CMD_DERIVE, 8'd1, 32'h0, 32'h0, 1'b0);
        send(CMD_OBSERVE, 8'd2, 32'h0, 32'h0, 1'b0);
        send(CMD_DERIVE, 8'd2, 32'h0, 32'h0, 1'b1);
        send(CMD_OBSERVE, 8'd3, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send(CMD_DERIVE, 8'd3, 32'h0, 32'h0, 1'b0);
        send(CMD_OBSERVE, 8'd4, 32'h8000_0000, 32'h0000_0001, 1'b0);
        send(CMD_OBSERVE, 8'd4, 32'hFFFF_FFFB, 32'h7FFF_FFFF, 1'b1);
        send(CMD_DERIVE, 8'd4, 32'h0, 32'h0, 1'b0);
        send(CMD_OBSERVE, 8'd255, 32'h0000_0001, 32'h0000_0002, 1'b1);
        send(CMD_OBSERVE, 8'd255, 32'hFFFF_0000, 32'h0001_0000, 1'b0);
        send(CMD_DERIVE, 8'd255, 32'h0, 32'h0, 1'b0);
        settle();
        write_reg(REG_MODE, 17'd1);
        write_reg(REG_WEIGHT, WEIGHT_ONE);
        send(CMD_OBSERVE, 8'd6, 32'hFFFE_0000, 32'h0002_0000, 1'b1);
        send(CMD_OBSERVE, 8'd6, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send(CMD_DERIVE, 8'd6, 32'h0, 32'h0, 1'b0);
        settle();

        modes   = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
        weights = '{17'd655, 17'd655, 17'd0, 17'h1_FFFF, 17'd32768, 17'd65535};
        weights[4] = 17'($urandom_range(1, 65535));
        for (int p = 0; p < 6; p++) begin
            write_reg(REG_MODE, {16'd0, modes[p]});
            write_reg(REG_WEIGHT, weights[p]);
            random_traffic(140);
            settle();
        end

        $display("Sent %0d observe and %0d derive items; %0d results checked.",
                 observes_sent, derives_sent, results_seen);
        if (failures == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
